// ----- rtl/pid_aw_pkg.sv -----
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, operation codes and division constants.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

  localparam int GAIN_W  = 16;
  localparam int DATA_W  = 32;
  localparam int ERR_W   = 33;
  localparam int DERR_W  = 34;
  localparam int PROD_W  = 50;
  localparam int MAG_W   = 49;
  localparam int TERM_W  = 44;
  localparam int ACC_W   = 45;
  localparam int SUM_W   = 46;
  localparam int IDX_W   = 3;

  // Operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_MIN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_MAX    = 3'd4;

  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sh7FFF_FFFF;

  // Division by 100: floor(2^32 / 100), then one compare and subtract.
  localparam int          DIV_LAT     = 7;
  localparam int          SPLIT_W     = 24;
  localparam int          HI_W        = 25;
  localparam int          QH_W        = 19;
  localparam int          LO_N_W      = 31;
  localparam int          RECIP_W     = 26;
  localparam logic [25:0] RECIP       = 26'd42949672;
  localparam logic [7:0]  DIVISOR     = 8'd100;

endpackage

// ----- rtl/pid_aw_div100.sv -----
// ----------------------------------------------------------------------------
// Pipelined signed division by 100
// Truncates toward zero. The magnitude is split into a high and a low part,
// each divided by a reciprocal multiply with a single correction step.
// ----------------------------------------------------------------------------
module pid_aw_div100 (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [pid_aw_pkg::PROD_W-1:0]   x,
  output logic signed [pid_aw_pkg::TERM_W-1:0]   q
);

  logic                                  sgn1, sgn2, sgn3, sgn4, sgn5, sgn6;
  logic [pid_aw_pkg::MAG_W-1:0]          mag1;
  logic [pid_aw_pkg::HI_W-1:0]           nh2;
  logic [pid_aw_pkg::SPLIT_W-1:0]        nl2, nl3;
  logic [pid_aw_pkg::HI_W+pid_aw_pkg::RECIP_W-1:0] ph2;
  logic [pid_aw_pkg::QH_W-1:0]           qh0, qh3, qh4, qh5, qh6;
  logic [pid_aw_pkg::HI_W-1:0]           rh_full;
  logic [7:0]                            rh3, rlo;
  logic [pid_aw_pkg::LO_N_W-1:0]         n24, n25;
  logic [pid_aw_pkg::LO_N_W+pid_aw_pkg::RECIP_W-1:0] p5;
  logic [pid_aw_pkg::SPLIT_W-1:0]        q20, q6, q2;
  logic [pid_aw_pkg::LO_N_W-1:0]         r_full;
  logic [7:0]                            r6;
  logic [pid_aw_pkg::QH_W+pid_aw_pkg::SPLIT_W-1:0] mag_q;

  assign qh0     = ph2[pid_aw_pkg::HI_W+pid_aw_pkg::RECIP_W-1:32];
  assign rh_full = nh2 - pid_aw_pkg::HI_W'(qh0) * pid_aw_pkg::HI_W'(pid_aw_pkg::DIVISOR);
  assign rlo     = (rh3 >= pid_aw_pkg::DIVISOR) ? rh3 - pid_aw_pkg::DIVISOR : rh3;
  assign q20     = p5[55:32];
  assign r_full  = n25 - pid_aw_pkg::LO_N_W'(q20) * pid_aw_pkg::LO_N_W'(pid_aw_pkg::DIVISOR);
  assign q2      = (r6 >= pid_aw_pkg::DIVISOR) ? q6 + 1'b1 : q6;
  assign mag_q   = {qh6, q2};

  always_ff @(posedge clk) begin
    if (en) begin
      sgn1 <= x[pid_aw_pkg::PROD_W-1];
      mag1 <= x[pid_aw_pkg::PROD_W-1] ? pid_aw_pkg::MAG_W'(-x) : pid_aw_pkg::MAG_W'(x);

      sgn2 <= sgn1;
      nh2  <= mag1[pid_aw_pkg::MAG_W-1:pid_aw_pkg::SPLIT_W];
      nl2  <= mag1[pid_aw_pkg::SPLIT_W-1:0];
      ph2  <= (pid_aw_pkg::HI_W+pid_aw_pkg::RECIP_W)'(mag1[pid_aw_pkg::MAG_W-1:pid_aw_pkg::SPLIT_W])
              * (pid_aw_pkg::HI_W+pid_aw_pkg::RECIP_W)'(pid_aw_pkg::RECIP);

      sgn3 <= sgn2;
      nl3  <= nl2;
      qh3  <= qh0;
      rh3  <= rh_full[7:0];

      sgn4 <= sgn3;
      qh4  <= (rh3 >= pid_aw_pkg::DIVISOR) ? qh3 + 1'b1 : qh3;
      n24  <= {rlo[6:0], nl3};

      sgn5 <= sgn4;
      qh5  <= qh4;
      n25  <= n24;
      p5   <= (pid_aw_pkg::LO_N_W+pid_aw_pkg::RECIP_W)'(n24)
              * (pid_aw_pkg::LO_N_W+pid_aw_pkg::RECIP_W)'(pid_aw_pkg::RECIP);

      sgn6 <= sgn5;
      qh6  <= qh5;
      q6   <= q20;
      r6   <= r_full[7:0];

      q    <= sgn6 ? -$signed(pid_aw_pkg::TERM_W'(mag_q))
                   :  $signed(pid_aw_pkg::TERM_W'(mag_q));
    end
  end

endmodule

// ----- rtl/pid_controller_antiwindup.sv -----
// ----------------------------------------------------------------------------
// PID controller with integral clamp
// Computes P, I and D terms in hundredths, clamps the integral and the output
// to the configured limits and flags integral windup.
// ----------------------------------------------------------------------------
//  channel  direction  signals
//  in       sink       in_valid, in_ready, operation, target, measured
//  out      source     out_valid, out_ready, drive, windup_active
//  cfg      sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One beat is accepted every cycle while the output is not stalled; a result
// passes the seven-stage divide-by-100 pipeline between the product and term
// registers. The integral add and clamp is combinational into its register.
// A stall on the output freezes the whole pipeline and holds in_ready low.
// Synchronous reset clears the pipeline, the stored error and the integral,
// and loads the default gains and limits.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   operation,
  input  logic signed [pid_aw_pkg::DATA_W-1:0]   target,
  input  logic signed [pid_aw_pkg::DATA_W-1:0]   measured,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pid_aw_pkg::DATA_W-1:0]   drive,
  output logic                                   windup_active,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pid_aw_pkg::IDX_W-1:0]           cfg_index,
  input  logic [pid_aw_pkg::DATA_W-1:0]          cfg_data
);

  localparam int LAT = pid_aw_pkg::DIV_LAT;

  logic signed [pid_aw_pkg::GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain;
  logic signed [pid_aw_pkg::DATA_W-1:0]  out_min, out_max;

  logic                                  en;
  logic                                  v1, v2, v3, va, vs;
  logic                                  op1, op2, op3, opa, ops;
  logic [LAT-1:0]                        vd, opd;
  logic signed [pid_aw_pkg::DATA_W-1:0]  tgt1, meas1;
  logic signed [pid_aw_pkg::ERR_W-1:0]   err_c, err2, last_err;
  logic signed [pid_aw_pkg::DERR_W-1:0]  derr_c, derr2;
  logic signed [pid_aw_pkg::PROD_W-1:0]  p_prod, i_prod, d_prod;
  logic signed [pid_aw_pkg::TERM_W-1:0]  p_q, i_q, d_q, pa, da;
  logic signed [pid_aw_pkg::DATA_W-1:0]  integ_acc, acca, acc_next;
  logic signed [pid_aw_pkg::ACC_W-1:0]   acc_sum;
  logic                                  wind_next, winda, winds;
  logic signed [pid_aw_pkg::SUM_W-1:0]   ysum, y_hi;
  logic signed [pid_aw_pkg::DATA_W-1:0]  drive_next;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      out_min    <= pid_aw_pkg::OUT_MIN_RST;
      out_max    <= pid_aw_pkg::OUT_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pid_aw_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data[pid_aw_pkg::GAIN_W-1:0];
        pid_aw_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data[pid_aw_pkg::GAIN_W-1:0];
        pid_aw_pkg::REG_DERIV_GAIN: deriv_gain <= cfg_data[pid_aw_pkg::GAIN_W-1:0];
        pid_aw_pkg::REG_OUT_MIN:    out_min    <= cfg_data;
        pid_aw_pkg::REG_OUT_MAX:    out_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign err_c  = pid_aw_pkg::ERR_W'(tgt1) - pid_aw_pkg::ERR_W'(meas1);
  assign derr_c = pid_aw_pkg::DERR_W'(err_c) - pid_aw_pkg::DERR_W'(last_err);

  always_comb begin
    acc_sum   = pid_aw_pkg::ACC_W'(integ_acc) + pid_aw_pkg::ACC_W'(i_q);
    acc_next  = acc_sum[pid_aw_pkg::DATA_W-1:0];
    wind_next = 1'b0;
    if (acc_sum > pid_aw_pkg::ACC_W'(out_max)) begin
      acc_next  = out_max;
      wind_next = 1'b1;
    end else if (acc_sum < pid_aw_pkg::ACC_W'(out_min)) begin
      acc_next  = out_min;
      wind_next = 1'b1;
    end
  end

  always_comb begin
    y_hi = (ysum > pid_aw_pkg::SUM_W'(out_max)) ? pid_aw_pkg::SUM_W'(out_max) : ysum;
    if (y_hi < pid_aw_pkg::SUM_W'(out_min)) begin
      drive_next = out_min;
    end else begin
      drive_next = y_hi[pid_aw_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      vd        <= '0;
      va        <= 1'b0;
      vs        <= 1'b0;
      out_valid <= 1'b0;
      last_err  <= '0;
      integ_acc <= '0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      vd        <= {vd[LAT-2:0], v3};
      va        <= vd[LAT-1];
      vs        <= va;
      out_valid <= vs;
      if (v1) begin
        last_err <= (op1 == pid_aw_pkg::OP_CLEAR) ? '0 : err_c;
      end
      if (vd[LAT-1]) begin
        integ_acc <= (opd[LAT-1] == pid_aw_pkg::OP_CLEAR) ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= operation;
      tgt1   <= target;
      meas1  <= measured;

      op2    <= op1;
      err2   <= err_c;
      derr2  <= derr_c;

      op3    <= op2;
      p_prod <= pid_aw_pkg::PROD_W'(prop_gain) * pid_aw_pkg::PROD_W'(err2);
      i_prod <= pid_aw_pkg::PROD_W'(integ_gain) * pid_aw_pkg::PROD_W'(err2);
      d_prod <= pid_aw_pkg::PROD_W'(deriv_gain) * pid_aw_pkg::PROD_W'(derr2);

      opd    <= {opd[LAT-2:0], op3};

      opa    <= opd[LAT-1];
      pa     <= p_q;
      da     <= d_q;
      acca   <= acc_next;
      winda  <= wind_next;

      ops    <= opa;
      ysum   <= pid_aw_pkg::SUM_W'(pa) + pid_aw_pkg::SUM_W'(acca) + pid_aw_pkg::SUM_W'(da);
      winds  <= winda;

      if (ops == pid_aw_pkg::OP_CLEAR) begin
        drive         <= '0;
        windup_active <= 1'b0;
      end else begin
        drive         <= drive_next;
        windup_active <= winds;
      end
    end
  end

  pid_aw_div100 u_div_p (.clk(clk), .en(en), .x(p_prod), .q(p_q));
  pid_aw_div100 u_div_i (.clk(clk), .en(en), .x(i_prod), .q(i_q));
  pid_aw_div100 u_div_d (.clk(clk), .en(en), .x(d_prod), .q(d_q));

endmodule

// ----- rtl/pid_aw_checker.sv -----
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the top-level ports for reset, stall and flow-control behavior.
// ----------------------------------------------------------------------------
module pid_aw_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_ready,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [pid_aw_pkg::DATA_W-1:0]   drive,
  input  logic                                   windup_active
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid high after reset.");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while output stage is empty.");

  a_drain_takes_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("Input stalled while output beat is taken.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(windup_active))
    else $error("Output beat changed while stalled.");

endmodule

bind pid_controller_antiwindup pid_aw_checker u_pid_aw_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .drive(drive),
  .windup_active(windup_active)
);
